### sv/blm_pkg.sv
package blm_pkg;

  // Window store depth
  localparam int unsigned WINDOW_MAX = 16;
  localparam int unsigned WIN_AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LEN_W      = $clog2(WINDOW_MAX + 1);

  // Field widths
  localparam int unsigned ADC_W    = 12;
  localparam int unsigned GAIN_W   = 20;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = ADC_W + GAIN_W;
  localparam int unsigned MV_W     = 16;
  localparam int unsigned VOLT_W   = 14;
  localparam int unsigned STORE_W  = 14;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned LENF_W   = 5;
  localparam int unsigned TENTHS_W = 10;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 20;
  localparam int unsigned SUM_W    = STORE_W + WIN_AW;
  localparam int unsigned NUM_W    = 24;
  localparam int unsigned QBIT_W   = $clog2(NUM_W + 1);
  localparam int unsigned CMP_W    = VOLT_W + 3;
  localparam int unsigned THR_W    = PCT_W + 4;

  localparam logic [STORE_W-1:0]  STORE_MAX        = '1;
  localparam logic [CMP_W-1:0]    REJECT_MARGIN_MV = CMP_W'(1000);
  localparam logic [TENTHS_W-1:0] FULL_TENTHS      = TENTHS_W'(1000);

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(105626);
  localparam logic [VOLT_W-1:0] FULL_RST  = VOLT_W'(8400);
  localparam logic [VOLT_W-1:0] EMPTY_RST = VOLT_W'(6400);
  localparam logic [PCT_W-1:0]  LOW_RST   = PCT_W'(20);
  localparam logic [PCT_W-1:0]  CRIT_RST  = PCT_W'(10);
  localparam logic [LEN_W-1:0]  LEN_RST   = LEN_W'((WINDOW_MAX < 10) ? WINDOW_MAX : 10);

  typedef enum logic [CFG_AW-1:0] {
    REG_GAIN  = 3'd0,
    REG_FULL  = 3'd1,
    REG_EMPTY = 3'd2,
    REG_LOW   = 3'd3,
    REG_CRIT  = 3'd4,
    REG_WIN   = 3'd5
  } cfg_reg_e;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_NORMAL = 2'd0,
    LVL_LOW    = 2'd1,
    LVL_CRIT   = 2'd2
  } level_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_AVG   = 9'b000001000,
    S_NUM   = 9'b000010000,
    S_PDIV  = 9'b000100000,
    S_PWAIT = 9'b001000000,
    S_LVL   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic                start;
    logic [QBIT_W-1:0]   bits;
    logic [NUM_W-1:0]    dividend;
    logic [VOLT_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [NUM_W-1:0]  quot;
  } div_rsp_t;

endpackage

### sv/blm_adc_if.sv
interface blm_adc_if import blm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

### sv/blm_res_if.sv
interface blm_res_if import blm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MV_W-1:0]     sample_mv;
  logic [VOLT_W-1:0]   average_mv;
  logic [TENTHS_W-1:0] charge_tenths;
  logic [LEVEL_W-1:0]  charge_level;
  logic                reading_valid;

  modport source (output valid, output sample_mv, output average_mv, output charge_tenths,
                  output charge_level, output reading_valid, input ready);
  modport sink (input valid, input sample_mv, input average_mv, input charge_tenths,
                input charge_level, input reading_valid, output ready);
endinterface

### sv/blm_cfg_if.sv
interface blm_cfg_if import blm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] idx;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

### sv/battery_level_monitor.sv
// Channel   Port    Dir  Payload
// sample    adc_i   in   adc_code
// result    res_o   out  sample_mv, average_mv, charge_tenths, charge_level, reading_valid
// config    cfg_i   in   idx (register index), data
//
// One sample at a time. A rejected sample passes S_MUL, S_CHK and S_DONE before its result
// registers. An accepted sample also runs the restoring divider for the mean, and a second
// time for the percent when the mean lands inside the empty..full span; the divider makes one
// quotient bit per cycle. The next sample can transfer once the FSM is back in S_IDLE. The
// window lives in a 16-entry RAM read in S_MUL, ahead of its write-back in S_CHK.
// The result register lets the next sample transfer while a result waits; a second result
// stalls the input. Reset restores the register defaults and empties the window.
module battery_level_monitor import blm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  blm_adc_if.sink     adc_i,
  blm_res_if.source   res_o,
  blm_cfg_if.sink     cfg_i
);

  state_e state_q, state_d;

  logic [GAIN_W-1:0]  gain_q;
  logic [VOLT_W-1:0]  full_q;
  logic [VOLT_W-1:0]  empty_q;
  logic [PCT_W-1:0]   low_q;
  logic [PCT_W-1:0]   crit_q;
  logic [LEN_W-1:0]   len_q;

  logic [WIN_AW-1:0]  wp_q, wp_d;
  logic [LEN_W-1:0]   fill_q, fill_d;
  logic [SUM_W-1:0]   sum_q, sum_d;

  logic [ADC_W-1:0]    code_q;
  logic [PROD_W-1:0]   prod_q;
  logic [MV_W-1:0]     mv_q;
  logic [NUM_W-1:0]    numer_q, numer_d;
  logic [VOLT_W-1:0]   avg_q;
  logic [TENTHS_W-1:0] tenths_q;
  level_e              level_q, level_d;
  logic                valid_q;

  logic                out_valid_q;
  logic [MV_W-1:0]     out_mv_q;
  logic [VOLT_W-1:0]   out_avg_q;
  logic [TENTHS_W-1:0] out_tenths_q;
  logic [LEVEL_W-1:0]  out_level_q;
  logic                out_rv_q;

  logic                cfg_fire;
  logic                in_fire;
  logic                out_free;
  logic [LENF_W-1:0]   len_field;
  logic [LEN_W-1:0]    len_new;

  logic [MV_W-1:0]     mv;
  logic                mv_ok;
  logic [STORE_W-1:0]  stored;
  logic [STORE_W-1:0]  old_sample;
  logic                win_full;
  logic [LEN_W-1:0]    pos_inc;
  logic                ram_we;
  logic                ram_re;

  logic                flat;
  logic [VOLT_W-1:0]   span;
  logic [THR_W-1:0]    low_thr;
  logic [THR_W-1:0]    crit_thr;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign in_fire     = adc_i.valid && adc_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign cfg_i.ready = 1'b1;
  assign adc_i.ready = (state_q == S_IDLE);

  // Clamp the written window length to 1..WINDOW_MAX
  assign len_field = cfg_i.data[LENF_W-1:0];
  always_comb begin
    if (len_field == '0) begin
      len_new = LEN_W'(1);
    end else if (32'(len_field) > WINDOW_MAX) begin
      len_new = LEN_W'(WINDOW_MAX);
    end else begin
      len_new = LEN_W'(len_field);
    end
  end

  // Sample check and window update
  assign mv         = prod_q[PROD_W-1:FRAC_W];
  assign mv_ok      = CMP_W'(mv) <= (CMP_W'(full_q) + REJECT_MARGIN_MV);
  assign stored     = (mv > MV_W'(STORE_MAX)) ? STORE_MAX : mv[STORE_W-1:0];
  assign win_full   = fill_q >= len_q;
  assign pos_inc    = LEN_W'(wp_q) + LEN_W'(1);
  assign sum_d      = sum_q - (win_full ? SUM_W'(old_sample) : '0) + SUM_W'(stored);
  assign fill_d     = win_full ? len_q : fill_q + LEN_W'(1);
  assign wp_d       = (pos_inc >= len_q) ? '0 : pos_inc[WIN_AW-1:0];
  assign ram_we     = (state_q == S_CHK) && mv_ok;
  assign ram_re     = (state_q == S_MUL);

  // Percent interpolation and level thresholds
  assign flat     = empty_q >= full_q;
  assign span     = full_q - empty_q;
  assign numer_d  = NUM_W'(avg_q - empty_q) * NUM_W'(FULL_TENTHS);
  assign low_thr  = THR_W'(low_q) * THR_W'(10);
  assign crit_thr = THR_W'(crit_q) * THR_W'(10);

  always_comb begin
    if (THR_W'(tenths_q) >= low_thr) begin
      level_d = LVL_NORMAL;
    end else if (THR_W'(tenths_q) >= crit_thr) begin
      level_d = LVL_LOW;
    end else begin
      level_d = LVL_CRIT;
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.bits     = QBIT_W'(SUM_W);
    div_req.dividend = {sum_d, {(NUM_W - SUM_W){1'b0}}};
    div_req.divisor  = VOLT_W'(fill_d);
    if (state_q == S_CHK) begin
      div_req.start = mv_ok;
    end else if (state_q == S_PDIV) begin
      div_req.start    = 1'b1;
      div_req.bits     = QBIT_W'(NUM_W);
      div_req.dividend = numer_q;
      div_req.divisor  = span;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_MUL;
      S_MUL:   state_d = S_CHK;
      S_CHK:   state_d = mv_ok ? S_AVG : S_DONE;
      S_AVG:   if (div_rsp.done) state_d = S_NUM;
      S_NUM: begin
        if (avg_q <= empty_q || flat || avg_q >= full_q) begin
          state_d = S_LVL;
        end else begin
          state_d = S_PDIV;
        end
      end
      S_PDIV:  state_d = S_PWAIT;
      S_PWAIT: if (div_rsp.done) state_d = S_LVL;
      S_LVL:   state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_q      <= GAIN_RST;
      full_q      <= FULL_RST;
      empty_q     <= EMPTY_RST;
      low_q       <= LOW_RST;
      crit_q      <= CRIT_RST;
      len_q       <= LEN_RST;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      tenths_q    <= '0;
      level_q     <= LVL_NORMAL;
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        case (cfg_reg_e'(cfg_i.idx))
          REG_GAIN:  gain_q  <= cfg_i.data[GAIN_W-1:0];
          REG_FULL:  full_q  <= cfg_i.data[VOLT_W-1:0];
          REG_EMPTY: empty_q <= cfg_i.data[VOLT_W-1:0];
          REG_LOW:   low_q   <= cfg_i.data[PCT_W-1:0];
          REG_CRIT:  crit_q  <= cfg_i.data[PCT_W-1:0];
          REG_WIN: begin
            len_q  <= len_new;
            wp_q   <= '0;
            fill_q <= '0;
            sum_q  <= '0;
          end
          default: ;
        endcase
      end else if (ram_we) begin
        wp_q   <= wp_d;
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end

      if (state_q == S_CHK) valid_q <= mv_ok;
      if (state_q == S_AVG && div_rsp.done) avg_q <= div_rsp.quot[STORE_W-1:0];
      if (state_q == S_NUM) begin
        if (avg_q <= empty_q) begin
          tenths_q <= '0;
        end else if (flat || avg_q >= full_q) begin
          tenths_q <= FULL_TENTHS;
        end
      end
      if (state_q == S_PWAIT && div_rsp.done) tenths_q <= div_rsp.quot[TENTHS_W-1:0];
      if (state_q == S_LVL) level_q <= level_d;

      // Hold the result until transferred
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) code_q <= adc_i.adc_code;
    if (state_q == S_MUL) prod_q <= PROD_W'(code_q) * PROD_W'(gain_q);
    if (state_q == S_CHK) mv_q <= mv;
    if (state_q == S_NUM) numer_q <= numer_d;
    if (state_q == S_DONE && out_free) begin
      out_mv_q     <= mv_q;
      out_avg_q    <= avg_q;
      out_tenths_q <= tenths_q;
      out_level_q  <= level_q;
      out_rv_q     <= valid_q;
    end
  end

  blm_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (STORE_W)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (stored),
    .re_i    (ram_re),
    .raddr_i (wp_q),
    .rdata_o (old_sample)
  );

  blm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign res_o.valid         = out_valid_q;
  assign res_o.sample_mv     = out_mv_q;
  assign res_o.average_mv    = out_avg_q;
  assign res_o.charge_tenths = out_tenths_q;
  assign res_o.charge_level  = out_level_q;
  assign res_o.reading_valid = out_rv_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= len_q)
    else $error("fill count beyond window length");

  assert property (@(posedge clk_i) disable iff (!rst_ni) LEN_W'(wp_q) < len_q)
    else $error("write position outside window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_CHK && !mv_ok) |=> $stable(sum_q) && $stable(fill_q) && $stable(wp_q))
    else $error("rejected sample changed the window");

  assert property (@(posedge clk_i) disable iff (!rst_ni) tenths_q <= FULL_TENTHS)
    else $error("charge estimate above full scale");

endmodule

### sv/blm_ram.sv
module blm_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 14,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/blm_div.sv
module blm_div import blm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q;
  logic                done_q;
  logic [QBIT_W-1:0]   cnt_q;
  logic [VOLT_W-1:0]   rem_q;
  logic [NUM_W-1:0]    quo_q;
  logic [VOLT_W-1:0]   dvs_q;
  logic [VOLT_W:0]     trial;
  logic [VOLT_W:0]     diff;
  logic                fits;
  logic [VOLT_W-1:0]   rem_d;

  // Restoring division, one quotient bit per cycle from the top of a left-aligned dividend
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};
  assign rem_d = fits ? diff[VOLT_W-1:0] : trial[VOLT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.bits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - QBIT_W'(1);
        if (cnt_q == QBIT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

endmodule
